/* src/mbbp_pkg.sv */
// shared command codes, register indexes, constants and queue entry type
package mbbp_pkg;

    // command codes, also used as the kind of a queued entry
    localparam logic [1:0] CMD_WRITE  = 2'd0;
    localparam logic [1:0] CMD_READ   = 2'd1;
    localparam logic [1:0] CMD_CLEAR  = 2'd2;
    localparam logic [1:0] CMD_IGNORE = 2'd3;

    // configuration register indexes
    localparam logic [1:0] REG_SCAN_ORDER   = 2'd0;
    localparam logic [1:0] REG_IMAGE_WIDTH  = 2'd1;
    localparam logic [1:0] REG_IMAGE_HEIGHT = 2'd2;

    // scan order codes
    localparam logic [2:0] SCAN_VCOL_LSB  = 3'd0;
    localparam logic [2:0] SCAN_VCOL_MSB  = 3'd1;
    localparam logic [2:0] SCAN_HROW_LSB  = 3'd2;
    localparam logic [2:0] SCAN_HROW_MSB  = 3'd3;
    localparam logic [2:0] SCAN_VPAGE_MSB = 3'd4;
    localparam logic [2:0] SCAN_VPAGE_LSB = 3'd5;
    localparam logic [2:0] SCAN_HCOL_LSB  = 3'd6;
    localparam logic [2:0] SCAN_HCOL_MSB  = 3'd7;

    // frame limits and gray threshold
    localparam int MAX_WIDTH   = 128;
    localparam int MAX_HEIGHT  = 64;
    localparam int GRAY_LIMIT  = 128;

    // depth of the queue between front and back
    localparam int QUEUE_DEPTH = 2;

    // classified command as it travels from front to back
    typedef struct packed {
        logic [1:0] kind;
        logic [9:0] idx;
        logic [2:0] bitpos;
        logic       dark;
        logic       oor;
    } cmd_t;

endpackage

/* src/mono_bitmap_byte_packer.sv */
// top level: configuration registers, front end, command queue and back end
// Packs RGB pixels into a one-bit-per-pixel byte store for a monochrome panel.
// Commands enter on start when busy is low, with mode selecting a pixel write
// (pix_x, pix_y, red, green, blue), a byte read (read_index) or a store clear.
// Every command gives exactly one result, shown for one cycle with done high;
// the receiver cannot stall, so results are never held back.
// A command passes through the queue and then the back end's command register, where its result is shown.
// Throughput: one write or read per cycle while busy is low; the store
// read-modify-write is forwarded, so back-to-back writes to one byte keep that pace.
// A clear gives its result at once, then sweeps the store one byte a cycle
// with busy high for the whole sweep; commands queued behind the clear
// (at most two) start only once the sweep has ended.
// Reset: scan_order 0, width 128, height 64, and a clearing sweep of every
// store byte, during which busy is high and no command is taken.
// Configuration writes (cfg_write, cfg_index, cfg_data) take effect at once
// and are meant for when the block is idle.
module mono_bitmap_byte_packer #(
    parameter int STORE_BYTES = 1024
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       start,
    output logic       busy,
    input  logic [1:0] mode,
    input  logic [6:0] pix_x,
    input  logic [5:0] pix_y,
    input  logic [7:0] red,
    input  logic [7:0] green,
    input  logic [7:0] blue,
    input  logic [9:0] read_index,
    input  logic       cfg_write,
    input  logic [1:0] cfg_index,
    input  logic [7:0] cfg_data,
    output logic       done,
    output logic [9:0] byte_index,
    output logic [2:0] bit_position,
    output logic       dark,
    output logic [7:0] read_data,
    output logic       out_of_range
);
    import mbbp_pkg::*;

    logic [2:0] scan_order_reg;
    logic [7:0] image_width_reg;
    logic [6:0] image_height_reg;
    cmd_t       front_cmd;
    cmd_t       q_head;
    logic       q_valid;
    logic       q_full;
    logic       q_pop;
    logic       sweeping;
    logic       accept;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            scan_order_reg   <= SCAN_VCOL_LSB;
            image_width_reg  <= 8'(MAX_WIDTH);
            image_height_reg <= 7'(MAX_HEIGHT);
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                REG_SCAN_ORDER:   scan_order_reg   <= cfg_data[2:0];
                REG_IMAGE_WIDTH:  image_width_reg  <= cfg_data;
                REG_IMAGE_HEIGHT: image_height_reg <= cfg_data[6:0];
                default:          ;
            endcase
        end
    end

    // command transfer
    assign busy   = q_full || sweeping;
    assign accept = start && !busy;

    mbbp_front #(
        .STORE_BYTES (STORE_BYTES)
    ) u_front (
        .scan_order   (scan_order_reg),
        .image_width  (image_width_reg),
        .image_height (image_height_reg),
        .mode         (mode),
        .pix_x        (pix_x),
        .pix_y        (pix_y),
        .red          (red),
        .green        (green),
        .blue         (blue),
        .read_index   (read_index),
        .cmd          (front_cmd)
    );

    mbbp_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (accept),
        .push_cmd (front_cmd),
        .pop      (q_pop),
        .head     (q_head),
        .valid    (q_valid),
        .full     (q_full)
    );

    mbbp_back #(
        .STORE_BYTES (STORE_BYTES)
    ) u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .q_valid      (q_valid),
        .q_head       (q_head),
        .pop          (q_pop),
        .sweeping     (sweeping),
        .done         (done),
        .byte_index   (byte_index),
        .bit_position (bit_position),
        .dark         (dark),
        .read_data    (read_data),
        .out_of_range (out_of_range)
    );

endmodule

/* src/mbbp_front.sv */
// front end: gray test, frame bounds and byte/bit location of each command
module mbbp_front #(
    parameter int STORE_BYTES = 1024
) (
    input  logic [2:0]     scan_order,
    input  logic [7:0]     image_width,
    input  logic [6:0]     image_height,
    input  logic [1:0]     mode,
    input  logic [6:0]     pix_x,
    input  logic [5:0]     pix_y,
    input  logic [7:0]     red,
    input  logic [7:0]     green,
    input  logic [7:0]     blue,
    input  logic [9:0]     read_index,
    output mbbp_pkg::cmd_t cmd
);
    import mbbp_pkg::*;

    logic [7:0]  w;
    logic [6:0]  h;
    logic [3:0]  pages;
    logic [4:0]  cols;
    logic [7:0]  mul_a;
    logic [4:0]  mul_b;
    logic [6:0]  add_c;
    logic [2:0]  sub_bit;
    logic        msb_first;
    logic [12:0] pix_idx;
    logic [10:0] frame_bytes;
    logic [12:0] gray_sum;
    logic [7:0]  gray;
    logic        is_dark;
    logic        pix_in_frame;
    logic        pix_in_store;
    logic        rd_ok;

    // clamp frame size and derive page and byte-column counts
    assign w     = (image_width > 8'(MAX_WIDTH)) ? 8'(MAX_WIDTH) : image_width;
    assign h     = (image_height > 7'(MAX_HEIGHT)) ? 7'(MAX_HEIGHT) : image_height;
    assign pages = 4'((8'(h) + 8'd7) >> 3);
    assign cols  = 5'((9'(w) + 9'd7) >> 3);

    // operand selection for the shared index multiplier
    always_comb
    begin
        unique case (scan_order)
            SCAN_VCOL_LSB, SCAN_VCOL_MSB:
            begin
                mul_a   = 8'(pix_x);
                mul_b   = 5'(pages);
                add_c   = 7'(pix_y[5:3]);
                sub_bit = pix_y[2:0];
            end
            SCAN_HROW_LSB, SCAN_HROW_MSB:
            begin
                mul_a   = 8'(pix_y);
                mul_b   = cols;
                add_c   = 7'(pix_x[6:3]);
                sub_bit = pix_x[2:0];
            end
            SCAN_VPAGE_MSB, SCAN_VPAGE_LSB:
            begin
                mul_a   = w;
                mul_b   = 5'(pix_y[5:3]);
                add_c   = pix_x;
                sub_bit = pix_y[2:0];
            end
            SCAN_HCOL_LSB, SCAN_HCOL_MSB:
            begin
                mul_a   = 8'(h);
                mul_b   = 5'(pix_x[6:3]);
                add_c   = 7'(pix_y);
                sub_bit = pix_x[2:0];
            end
        endcase
    end

    // first pixel of a group in the top bit
    assign msb_first = (scan_order == SCAN_VCOL_MSB) || (scan_order == SCAN_HROW_MSB) ||
                       (scan_order == SCAN_VPAGE_MSB) || (scan_order == SCAN_HCOL_MSB);

    // byte index of the pixel
    assign pix_idx = 13'(mul_a) * 13'(mul_b) + 13'(add_c);

    // frame size in bytes, vertical groups for codes with bit 1 clear
    assign frame_bytes = scan_order[1] ? (11'(cols) * 11'(h)) : (11'(w) * 11'(pages));

    // gray level and dark test
    assign gray_sum = 13'(red) * 13'd11 + (13'(green) << 4) + 13'(blue) * 13'd5;
    assign gray     = 8'(gray_sum >> 5);
    assign is_dark  = gray < 8'(GRAY_LIMIT);

    // bounds checks
    assign pix_in_frame = (8'(pix_x) < w) && (7'(pix_y) < h);
    assign pix_in_store = 32'(pix_idx) < STORE_BYTES;
    assign rd_ok        = (11'(read_index) < frame_bytes) && (32'(read_index) < STORE_BYTES);

    // build the queue entry
    always_comb
    begin
        cmd = '0;
        unique case (mode)
            CMD_WRITE:
            begin
                cmd.kind = CMD_WRITE;
                cmd.dark = is_dark;
                if (pix_in_frame && pix_in_store)
                begin
                    cmd.idx    = pix_idx[9:0];
                    cmd.bitpos = sub_bit ^ {3{msb_first}};
                end
                else
                begin
                    cmd.oor = 1'b1;
                end
            end
            CMD_READ:
            begin
                cmd.kind = CMD_READ;
                cmd.idx  = read_index;
                cmd.oor  = !rd_ok;
            end
            CMD_CLEAR:
            begin
                cmd.kind = CMD_CLEAR;
            end
            CMD_IGNORE:
            begin
                cmd.kind = CMD_IGNORE;
            end
        endcase
    end

endmodule

/* src/mbbp_queue.sv */
// short fifo of classified commands between front and back
module mbbp_queue (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           push,
    input  mbbp_pkg::cmd_t push_cmd,
    input  logic           pop,
    output mbbp_pkg::cmd_t head,
    output logic           valid,
    output logic           full
);
    import mbbp_pkg::*;

    localparam int PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CW = $clog2(QUEUE_DEPTH + 1);

    cmd_t          slot_reg [QUEUE_DEPTH];
    logic [PW-1:0] wr_ptr_reg;
    logic [PW-1:0] wr_ptr_next;
    logic [PW-1:0] rd_ptr_reg;
    logic [PW-1:0] rd_ptr_next;
    logic [CW-1:0] count_reg;
    logic [CW-1:0] count_next;

    assign head  = slot_reg[rd_ptr_reg];
    assign valid = count_reg != '0;
    assign full  = count_reg == CW'(QUEUE_DEPTH);

    // pointer and fill count update
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // entry storage
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= push_cmd;
        end
    end

endmodule

/* src/mbbp_back.sv */
// back end: byte store, read-modify-write with forwarding, clearing sweep, results
module mbbp_back #(
    parameter int STORE_BYTES = 1024
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           q_valid,
    input  mbbp_pkg::cmd_t q_head,
    output logic           pop,
    output logic           sweeping,
    output logic           done,
    output logic [9:0]     byte_index,
    output logic [2:0]     bit_position,
    output logic           dark,
    output logic [7:0]     read_data,
    output logic           out_of_range
);
    import mbbp_pkg::*;

    localparam int AW = $clog2(STORE_BYTES);

    logic [7:0]    store [STORE_BYTES];
    cmd_t          act_reg;
    logic          act_valid_reg;
    logic [7:0]    mem_rd_reg;
    logic          fwd_hit_reg;
    logic [7:0]    fwd_byte_reg;
    logic          sweep_reg;
    logic          sweep_next;
    logic [AW-1:0] sweep_addr_reg;
    logic [AW-1:0] sweep_addr_next;
    logic          act_write;
    logic          act_clear;
    logic          fwd_hit;
    logic [7:0]    cur_byte;
    logic [7:0]    bit_mask;
    logic [7:0]    new_byte;

    // current command decode
    assign act_write = act_valid_reg && (act_reg.kind == CMD_WRITE) && !act_reg.oor;
    assign act_clear = act_valid_reg && (act_reg.kind == CMD_CLEAR);

    // stored byte, taking a write of the previous cycle to the same byte
    assign cur_byte = fwd_hit_reg ? fwd_byte_reg : mem_rd_reg;
    assign bit_mask = 8'd1 << act_reg.bitpos;
    assign new_byte = act_reg.dark ? (cur_byte | bit_mask) : (cur_byte & ~bit_mask);

    // take the next command unless a clear is starting or running
    assign pop      = q_valid && !sweep_reg && !act_clear;
    assign fwd_hit  = act_write && (q_head.idx == act_reg.idx);
    assign sweeping = sweep_reg;

    // clearing sweep control
    always_comb
    begin
        sweep_next      = sweep_reg;
        sweep_addr_next = sweep_addr_reg;
        if (act_clear)
        begin
            sweep_next      = 1'b1;
            sweep_addr_next = '0;
        end
        else if (sweep_reg)
        begin
            if (sweep_addr_reg == AW'(STORE_BYTES - 1))
            begin
                sweep_next = 1'b0;
            end
            else
            begin
                sweep_addr_next = sweep_addr_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            act_valid_reg  <= 1'b0;
            fwd_hit_reg    <= 1'b0;
            sweep_reg      <= 1'b1;
            sweep_addr_reg <= '0;
        end
        else
        begin
            act_valid_reg  <= pop;
            sweep_reg      <= sweep_next;
            sweep_addr_reg <= sweep_addr_next;
            if (pop)
            begin
                fwd_hit_reg <= fwd_hit;
            end
        end
    end

    // command and forwarded byte capture
    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            act_reg      <= q_head;
            fwd_byte_reg <= new_byte;
        end
    end

    // byte store: one write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (sweep_reg)
        begin
            store[sweep_addr_reg] <= '0;
        end
        else if (act_write)
        begin
            store[AW'(act_reg.idx)] <= new_byte;
        end
        if (pop)
        begin
            mem_rd_reg <= store[AW'(q_head.idx)];
        end
    end

    // result transfer
    assign done         = act_valid_reg;
    assign byte_index   = act_reg.idx;
    assign bit_position = act_reg.bitpos;
    assign dark         = act_reg.dark;
    assign out_of_range = act_reg.oor;

    always_comb
    begin
        priority if (act_write)
        begin
            read_data = new_byte;
        end
        else if ((act_reg.kind == CMD_READ) && !act_reg.oor)
        begin
            read_data = cur_byte;
        end
        else
        begin
            read_data = '0;
        end
    end

endmodule

/* tb/mbbp_checker.sv */
// checker for the bitmap byte packer: predicts each result and compares it on the done strobe
module mbbp_checker #(
    parameter int STORE_BYTES = 1024
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       start,
    input  logic       busy,
    input  logic [1:0] mode,
    input  logic [6:0] pix_x,
    input  logic [5:0] pix_y,
    input  logic [7:0] red,
    input  logic [7:0] green,
    input  logic [7:0] blue,
    input  logic [9:0] read_index,
    input  logic       cfg_write,
    input  logic [1:0] cfg_index,
    input  logic [7:0] cfg_data,
    input  logic       done,
    input  logic [9:0] byte_index,
    input  logic [2:0] bit_position,
    input  logic       dark,
    input  logic [7:0] read_data,
    input  logic       out_of_range,
    output int         fail_count,
    output int         results_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    import mbbp_pkg::*;

    localparam int GROUP   = 8;
    localparam int BIT_TOP = 7;

    typedef struct packed {
        logic [9:0] byte_index;
        logic [2:0] bit_position;
        logic       dark;
        logic [7:0] read_data;
        logic       out_of_range;
    } pack_result_t;

    // shadow copy of the byte store and the frame registers
    logic [7:0]   shadow_bytes [STORE_BYTES];
    logic [2:0]   scan_sel;
    logic [7:0]   frame_width;
    logic [6:0]   frame_height;
    pack_result_t due_results [$];

    // work out the result of one command and update the shadow store
    task automatic predict_pack(input logic [1:0] cmd, input logic [6:0] px,
                                input logic [5:0] py, input logic [7:0] r,
                                input logic [7:0] g, input logic [7:0] b,
                                input logic [9:0] ridx, output pack_result_t res);
        int unsigned fw, fh, pages, cols, gray, idx, bitn, frame_len;
        res = '0;
        fw = (frame_width > MAX_WIDTH) ? MAX_WIDTH : frame_width;
        fh = (frame_height > MAX_HEIGHT) ? MAX_HEIGHT : frame_height;
        pages = (fh + 7) / GROUP;
        cols = (fw + 7) / GROUP;
        case (scan_sel)
            SCAN_VCOL_LSB, SCAN_VCOL_MSB, SCAN_VPAGE_MSB, SCAN_VPAGE_LSB:
                frame_len = fw * pages;
            default:
                frame_len = cols * fh;
        endcase
        case (cmd)
            CMD_WRITE:
            begin
                gray = (11 * r + 16 * g + 5 * b) >> 5;
                res.dark = (gray < GRAY_LIMIT);
                if (px >= fw || py >= fh)
                begin
                    res.out_of_range = 1'b1;
                end
                else
                begin
                    case (scan_sel)
                        SCAN_VCOL_LSB, SCAN_VCOL_MSB:
                        begin
                            idx = px * pages + py / GROUP;
                            bitn = py % GROUP;
                        end
                        SCAN_HROW_LSB, SCAN_HROW_MSB:
                        begin
                            idx = py * cols + px / GROUP;
                            bitn = px % GROUP;
                        end
                        SCAN_VPAGE_MSB, SCAN_VPAGE_LSB:
                        begin
                            idx = (py / GROUP) * fw + px;
                            bitn = py % GROUP;
                        end
                        default:
                        begin
                            idx = (px / GROUP) * fh + py;
                            bitn = px % GROUP;
                        end
                    endcase
                    // msb-first orders put the first pixel of a group in bit 7
                    if (scan_sel == SCAN_VCOL_MSB || scan_sel == SCAN_HROW_MSB ||
                        scan_sel == SCAN_VPAGE_MSB || scan_sel == SCAN_HCOL_MSB)
                        bitn = BIT_TOP - bitn;
                    if (idx >= STORE_BYTES)
                    begin
                        res.out_of_range = 1'b1;
                    end
                    else
                    begin
                        shadow_bytes[idx][bitn] = res.dark;
                        res.byte_index = 10'(idx);
                        res.bit_position = 3'(bitn);
                        res.read_data = shadow_bytes[idx];
                    end
                end
            end
            CMD_READ:
            begin
                res.byte_index = ridx;
                if (ridx >= frame_len || ridx >= STORE_BYTES)
                    res.out_of_range = 1'b1;
                else
                    res.read_data = shadow_bytes[ridx];
            end
            CMD_CLEAR:
            begin
                for (int i = 0; i < STORE_BYTES; i++)
                    shadow_bytes[i] = 8'd0;
            end
            default:
            begin
                // unused code gives an all-zero result
            end
        endcase
    endtask

    task automatic check_field(input string label, input int unsigned want,
                               input int unsigned got);
        if (want != got)
        begin
            $error("%s: expected %0d, got %0d", label, want, got);
            fail_count++;
        end
    endtask

    // watch config writes, result strobes and command transfers
    always @(posedge clk or negedge rst_n)
    begin
        pack_result_t res;
        if (!rst_n)
        begin
            for (int i = 0; i < STORE_BYTES; i++)
                shadow_bytes[i] = 8'd0;
            scan_sel = SCAN_VCOL_LSB;
            frame_width = 8'd128;
            frame_height = 7'd64;
            due_results.delete();
            fail_count = 0;
            results_pending <= 0;
        end
        else
        begin
            if (cfg_write)
            begin
                case (cfg_index)
                    REG_SCAN_ORDER:   scan_sel = cfg_data[2:0];
                    REG_IMAGE_WIDTH:  frame_width = cfg_data;
                    REG_IMAGE_HEIGHT: frame_height = cfg_data[6:0];
                    default:          ;
                endcase
            end
            if (done)
            begin
                if (due_results.size() == 0)
                begin
                    $error("result with nothing expected, byte_index %0d", byte_index);
                    fail_count++;
                end
                else
                begin
                    res = due_results.pop_front();
                    check_field("byte_index", res.byte_index, byte_index);
                    check_field("bit_position", res.bit_position, bit_position);
                    check_field("dark", res.dark, dark);
                    check_field("read_data", res.read_data, read_data);
                    check_field("out_of_range", res.out_of_range, out_of_range);
                end
            end
            if (start && !busy)
            begin
                predict_pack(mode, pix_x, pix_y, red, green, blue, read_index, res);
                due_results.push_back(res);
            end
            results_pending <= due_results.size();
        end
    end

endmodule

/* tb/tb_top.sv */
// testbench top for the bitmap byte packer: clock, reset, command stimulus and verdict
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import mbbp_pkg::*;

    localparam int STORE_BYTES   = 1024;
    localparam int STALL_LIMIT   = 5000;
    localparam int SETTLE_CYCLES = 6;
    localparam int PHASES        = 12;
    localparam int PHASE_ITEMS   = 66;

    logic       clk = 1'b0;
    logic       rst_n;
    logic       start;
    logic       busy;
    logic [1:0] mode;
    logic [6:0] pix_x;
    logic [5:0] pix_y;
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic [9:0] read_index;
    logic       cfg_write;
    logic [1:0] cfg_index;
    logic [7:0] cfg_data;
    logic       done;
    logic [9:0] byte_index;
    logic [2:0] bit_position;
    logic       dark;
    logic [7:0] read_data;
    logic       out_of_range;
    int         fail_count;
    int         results_pending;
    int         stall_cycles;

    // frame setting as last written, for shaping the stimulus
    int         cur_scan;
    int         cur_w;
    int         cur_h;

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    mono_bitmap_byte_packer #(.STORE_BYTES(STORE_BYTES)) u_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .mode         (mode),
        .pix_x        (pix_x),
        .pix_y        (pix_y),
        .red          (red),
        .green        (green),
        .blue         (blue),
        .read_index   (read_index),
        .cfg_write    (cfg_write),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .done         (done),
        .byte_index   (byte_index),
        .bit_position (bit_position),
        .dark         (dark),
        .read_data    (read_data),
        .out_of_range (out_of_range)
    );

    mbbp_checker #(.STORE_BYTES(STORE_BYTES)) u_checker (
        .clk             (clk),
        .rst_n           (rst_n),
        .start           (start),
        .busy            (busy),
        .mode            (mode),
        .pix_x           (pix_x),
        .pix_y           (pix_y),
        .red             (red),
        .green           (green),
        .blue            (blue),
        .read_index      (read_index),
        .cfg_write       (cfg_write),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .done            (done),
        .byte_index      (byte_index),
        .bit_position    (bit_position),
        .dark            (dark),
        .read_data       (read_data),
        .out_of_range    (out_of_range),
        .fail_count      (fail_count),
        .results_pending (results_pending)
    );

    // watchdog: cycles without any transfer on either side
    always @(posedge clk)
    begin
        if (!rst_n || (start && !busy) || done || cfg_write)
            stall_cycles <= 0;
        else
            stall_cycles <= stall_cycles + 1;
        if (stall_cycles >= STALL_LIMIT)
        begin
            $display("tb: failure");
            $finish;
        end
    end

    // one command transfer, then an optional random gap
    task automatic send_cmd(input logic [1:0] m, input logic [6:0] x, input logic [5:0] y,
                            input logic [7:0] r, input logic [7:0] g, input logic [7:0] b,
                            input logic [9:0] ri, input bit allow_gap);
        int unsigned gap;
        start <= 1'b1;
        mode <= m;
        pix_x <= x;
        pix_y <= y;
        red <= r;
        green <= g;
        blue <= b;
        read_index <= ri;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        gap = allow_gap ? $urandom_range(0, 7) : 0;
        if (gap != 0)
        begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    // hold off until every expected result has come back
    task automatic drain_results();
        start <= 1'b0;
        @(posedge clk);
        while (results_pending != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // write all three frame registers, unused data bits random
    task automatic configure(input logic [2:0] scan, input logic [7:0] w, input logic [7:0] h);
        cfg_write <= 1'b1;
        cfg_index <= REG_SCAN_ORDER;
        cfg_data <= {5'($urandom), scan};
        @(posedge clk);
        cfg_index <= REG_IMAGE_WIDTH;
        cfg_data <= w;
        @(posedge clk);
        cfg_index <= REG_IMAGE_HEIGHT;
        cfg_data <= {1'($urandom), h[6:0]};
        @(posedge clk);
        cfg_write <= 1'b0;
        cur_scan = scan;
        cur_w = w;
        cur_h = h[6:0];
    endtask

    // mostly in-frame writes and reads, with some strays, clears and unused codes
    task automatic random_command(input bit allow_gap);
        int unsigned pick, fw, fh, frame_len;
        logic [1:0]  m;
        logic [6:0]  x;
        logic [5:0]  y;
        logic [7:0]  r, g, b;
        logic [9:0]  ri;
        fw = (cur_w > MAX_WIDTH) ? MAX_WIDTH : cur_w;
        fh = (cur_h > MAX_HEIGHT) ? MAX_HEIGHT : cur_h;
        if (cur_scan == SCAN_HROW_LSB || cur_scan == SCAN_HROW_MSB ||
            cur_scan == SCAN_HCOL_LSB || cur_scan == SCAN_HCOL_MSB)
            frame_len = ((fw + 7) / 8) * fh;
        else
            frame_len = fw * ((fh + 7) / 8);
        pick = $urandom_range(0, 99);
        m = (pick < 70) ? CMD_WRITE : (pick < 94) ? CMD_READ :
            (pick < 97) ? CMD_CLEAR : CMD_IGNORE;
        x = (fw != 0 && $urandom_range(0, 9) != 0) ? 7'($urandom_range(0, fw - 1)) : 7'($urandom);
        y = (fh != 0 && $urandom_range(0, 9) != 0) ? 6'($urandom_range(0, fh - 1)) : 6'($urandom);
        ri = (frame_len != 0 && $urandom_range(0, 9) < 8) ?
             10'($urandom_range(0, frame_len - 1)) : 10'($urandom);
        if ($urandom_range(0, 3) == 0)
        begin
            // colors around the dark threshold
            r = 8'($urandom_range(118, 138));
            g = 8'($urandom_range(118, 138));
            b = 8'($urandom_range(118, 138));
        end
        else
        begin
            r = 8'($urandom);
            g = 8'($urandom);
            b = 8'($urandom);
        end
        send_cmd(m, x, y, r, g, b, ri, allow_gap);
    endtask

    // frame setting of each random phase, extremes included
    task automatic phase_frame(input int p, output logic [2:0] scan,
                               output logic [7:0] w, output logic [7:0] h);
        case (p)
            0:       begin scan = SCAN_VCOL_LSB;  w = 8'd128; h = 8'd64;  end
            1:       begin scan = SCAN_VCOL_MSB;  w = 8'd13;  h = 8'd21;  end
            2:       begin scan = SCAN_HROW_LSB;  w = 8'd1;   h = 8'd1;   end
            3:       begin scan = SCAN_HROW_MSB;  w = 8'd255; h = 8'd127; end
            4:       begin scan = SCAN_VPAGE_MSB; w = 8'd37;  h = 8'd9;   end
            5:       begin scan = SCAN_VPAGE_LSB; w = 8'd128; h = 8'd64;  end
            6:       begin scan = SCAN_HCOL_LSB;  w = 8'd7;   h = 8'd64;  end
            7:       begin scan = SCAN_HCOL_MSB;  w = 8'd128; h = 8'd3;   end
            8:       begin scan = SCAN_VCOL_MSB;  w = 8'd0;   h = 8'd40;  end
            9:       begin scan = SCAN_HROW_MSB;  w = 8'd50;  h = 8'd0;   end
            default:
            begin
                scan = 3'($urandom);
                w = 8'($urandom_range(1, 140));
                h = 8'($urandom_range(1, 70));
            end
        endcase
    endtask

    initial
    begin
        logic [2:0] scan;
        logic [7:0] w, h;
        start <= 1'b0;
        mode <= CMD_WRITE;
        pix_x <= 7'd0;
        pix_y <= 6'd0;
        red <= 8'd0;
        green <= 8'd0;
        blue <= 8'd0;
        read_index <= 10'd0;
        cfg_write <= 1'b0;
        cfg_index <= REG_SCAN_ORDER;
        cfg_data <= 8'd0;
        rst_n <= 1'b0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;

        // wait out the clearing sweep after reset
        @(posedge clk);
        while (busy)
            @(posedge clk);

        // full frame: threshold edges, corners, same-byte writes, read, clear, unused code
        configure(SCAN_VCOL_LSB, 8'd128, 8'd64);
        send_cmd(CMD_WRITE, 7'd0, 6'd0, 8'd0, 8'd0, 8'd0, 10'($urandom), 1'b0);
        send_cmd(CMD_WRITE, 7'd0, 6'd1, 8'd255, 8'd255, 8'd255, 10'($urandom), 1'b0);
        send_cmd(CMD_WRITE, 7'd0, 6'd2, 8'd127, 8'd127, 8'd127, 10'($urandom), 1'b0);
        send_cmd(CMD_WRITE, 7'd0, 6'd3, 8'd128, 8'd128, 8'd128, 10'($urandom), 1'b0);
        send_cmd(CMD_WRITE, 7'd127, 6'd63, 8'd0, 8'd255, 8'd0, 10'($urandom), 1'b0);
        send_cmd(CMD_READ, 7'($urandom), 6'($urandom), 8'($urandom), 8'($urandom),
                 8'($urandom), 10'd0, 1'b0);
        send_cmd(CMD_READ, 7'($urandom), 6'($urandom), 8'($urandom), 8'($urandom),
                 8'($urandom), 10'd1023, 1'b0);
        send_cmd(CMD_IGNORE, 7'd127, 6'd63, 8'd255, 8'd255, 8'd255, 10'd1023, 1'b0);
        send_cmd(CMD_CLEAR, 7'd127, 6'd63, 8'd0, 8'd0, 8'd0, 10'd1023, 1'b0);
        send_cmd(CMD_READ, 7'd0, 6'd0, 8'd0, 8'd0, 8'd0, 10'd1023, 1'b0);
        send_cmd(CMD_WRITE, 7'd5, 6'd9, 8'd0, 8'd0, 8'd255, 10'd0, 1'b0);
        send_cmd(CMD_READ, 7'd0, 6'd0, 8'd0, 8'd0, 8'd0, 10'd41, 1'b0);

        // small frame, msb rows: pixels past the edge and a partial last byte
        drain_results();
        configure(SCAN_HROW_MSB, 8'd10, 8'd5);
        send_cmd(CMD_WRITE, 7'd10, 6'd0, 8'd0, 8'd0, 8'd0, 10'd0, 1'b0);
        send_cmd(CMD_WRITE, 7'd0, 6'd5, 8'd0, 8'd0, 8'd0, 10'd0, 1'b0);
        send_cmd(CMD_WRITE, 7'd9, 6'd4, 8'd0, 8'd0, 8'd0, 10'd0, 1'b0);
        send_cmd(CMD_READ, 7'd0, 6'd0, 8'd0, 8'd0, 8'd0, 10'd10, 1'b0);
        send_cmd(CMD_READ, 7'd0, 6'd0, 8'd0, 8'd0, 8'd0, 10'd9, 1'b0);

        // msb columns with a partial page
        drain_results();
        configure(SCAN_VCOL_MSB, 8'd3, 8'd5);
        send_cmd(CMD_WRITE, 7'd2, 6'd4, 8'd10, 8'd20, 8'd30, 10'd0, 1'b0);
        send_cmd(CMD_READ, 7'd0, 6'd0, 8'd0, 8'd0, 8'd0, 10'd2, 1'b0);
        send_cmd(CMD_READ, 7'd0, 6'd0, 8'd0, 8'd0, 8'd0, 10'd3, 1'b0);

        // column-major horizontal bytes, last byte of the store
        drain_results();
        configure(SCAN_HCOL_LSB, 8'd128, 8'd64);
        send_cmd(CMD_WRITE, 7'd127, 6'd63, 8'd1, 8'd2, 8'd3, 10'd0, 1'b0);
        send_cmd(CMD_READ, 7'd0, 6'd0, 8'd0, 8'd0, 8'd0, 10'd1023, 1'b0);

        // random phases, each under its own frame setting
        for (int p = 0; p < PHASES; p++)
        begin
            drain_results();
            phase_frame(p, scan, w, h);
            configure(scan, w, h);
            for (int n = 0; n < PHASE_ITEMS; n++)
                random_command(p % 3 != 0);
        end

        drain_results();
        if (fail_count == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
